// ===== hdl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/cbpm_pkg.sv =====
package cbpm_pkg;
   localparam logic [2:0] REQ_READ    = 3'd0;
   localparam logic [2:0] REQ_UNPIN   = 3'd1;
   localparam logic [2:0] REQ_ALLOC   = 3'd2;
   localparam logic [2:0] REQ_DISPOSE = 3'd3;
   localparam logic [2:0] REQ_FLUSH   = 3'd4;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WB     = 2'd1;
   localparam logic [1:0] KIND_FETCH  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXCEEDED  = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_NOT_PIN   = 3'd3;
   localparam logic [2:0] ST_PINNED    = 3'd4;
   localparam logic [2:0] ST_BAD       = 3'd5;

   localparam int SWEEP_ROUNDS = 2;

   // datapath operations on one frame or on the found frame
   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_HIT, OP_UNPIN, OP_WIPE_HIT, OP_SWEEP, OP_INSTALL, OP_FLUSH_STEP,
      OP_WB_TAKE, OP_GRANT_HIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       emit;
      logic [1:0] kind;
      logic [2:0] status;
      logic       use_frame; // status frame_index from granted frame
      logic       use_walk;  // write-back from walk pointer
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       hit;
      logic       hit_zero_pins;
      logic       hand_free;     // invalid at next hand
      logic       hand_ref;
      logic       hand_take;     // valid, ref 0, pins 0
      logic       hand_dirty;
      logic       sweep_done;
      logic       walk_match;
      logic       walk_pinned;
      logic       walk_dirty;
      logic       walk_end;
      logic       out_busy;
   } stat_type;
endpackage

// ===== hdl/clock_buffer_pool_manager.sv =====
// a read hit, unpin, dispose or bad request is answered with one status word from S_DECIDE, after S_MATCH
// a miss or alloc first sweeps the hand, with at most 2*NUM_FRAMES sweep steps that take no frame,
// and answers with an EXCEEDED status when that bound is reached
// a flush walks the frames one per cycle while the output is not stalled, stops at a pinned frame
// of its file, and else ends with an ok status; one request at a time, and output stalls hold it
// synchronous active-high reset clears all frames and sets the hand to the last frame
module clock_buffer_pool_manager #(
   parameter int NUM_FRAMES   = 16,
   parameter int FILE_ID_BITS = 8,
   parameter int PAGE_BITS    = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[2:0], file_id, page_no, mark_dirty, zero fill
   input  logic [((3 + FILE_ID_BITS + PAGE_BITS + 1 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind[1:0], status[2:0], frame_index[3:0], out_file, out_page, zero fill
   output logic [((9 + FILE_ID_BITS + PAGE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic        rsp_tlast
);
   `include "assert_macros.svh"
   localparam int OW = ((9 + FILE_ID_BITS + PAGE_BITS + 7) / 8) * 8;
   localparam int PADW = OW - 9 - FILE_ID_BITS - PAGE_BITS;

   cbpm_pkg::cmd_type  cmd;
   cbpm_pkg::stat_type stat;
   logic [1:0] k;
   logic [2:0] s;
   logic [3:0] fr;
   logic [FILE_ID_BITS-1:0] of;
   logic [PAGE_BITS-1:0] op;

   cbpm_control u_ctl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   cbpm_datapath #(.NUM_FRAMES(NUM_FRAMES), .FILE_ID_BITS(FILE_ID_BITS),
      .PAGE_BITS(PAGE_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .in_type(req_tdata[2:0]), .in_file(req_tdata[3 +: FILE_ID_BITS]),
      .in_page(req_tdata[3 + FILE_ID_BITS +: PAGE_BITS]),
      .in_dirty(req_tdata[3 + FILE_ID_BITS + PAGE_BITS]),
      .cmd(cmd), .stat(stat), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_kind(k), .out_status(s), .out_frame(fr), .out_file(of), .out_page(op),
      .out_last(rsp_tlast)
   );

   assign rsp_tdata = {{PADW{1'b0}}, op, of, fr, s, k};

   `ASSERT_IMPL(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `ASSERT_IMPL(a_ready_idle, clock, reset, req_tready |-> !cmd.emit, "emit while idle")
   `ASSERT_IMPL(a_last_status, clock, reset, rsp_tvalid && rsp_tlast |-> k == 2'd0, "last word")
endmodule

// ===== hdl/cbpm_datapath.sv =====
module cbpm_datapath #(
   parameter int NUM_FRAMES   = 16,
   parameter int FILE_ID_BITS = 8,
   parameter int PAGE_BITS    = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              in_type,
   input  logic [FILE_ID_BITS-1:0] in_file,
   input  logic [PAGE_BITS-1:0]    in_page,
   input  logic                    in_dirty,
   input  cbpm_pkg::cmd_type       cmd,
   output cbpm_pkg::stat_type      stat,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [1:0]              out_kind,
   output logic [2:0]              out_status,
   output logic [3:0]              out_frame,
   output logic [FILE_ID_BITS-1:0] out_file,
   output logic [PAGE_BITS-1:0]    out_page,
   output logic                    out_last
);
   localparam int IW = $clog2(NUM_FRAMES);
   localparam int SWEEP_ROUNDS_N = cbpm_pkg::SWEEP_ROUNDS * NUM_FRAMES;
   localparam int SW = $clog2(SWEEP_ROUNDS_N + 1);

   logic [NUM_FRAMES-1:0] valid_ff, valid_in, dirty_ff, dirty_in, ref_ff, ref_in;
   logic [7:0] pins_ff [NUM_FRAMES];
   logic [7:0] pins_in [NUM_FRAMES];
   logic [FILE_ID_BITS-1:0] file_ff [NUM_FRAMES];
   logic [FILE_ID_BITS-1:0] file_in [NUM_FRAMES];
   logic [PAGE_BITS-1:0] page_ff [NUM_FRAMES];
   logic [PAGE_BITS-1:0] page_in [NUM_FRAMES];
   logic [IW-1:0] hand_ff, hand_in, walk_ff, walk_in, hit_ff, hit_in, grant_ff, grant_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [2:0] type_ff, type_in;
   logic [FILE_ID_BITS-1:0] rfile_ff, rfile_in;
   logic [PAGE_BITS-1:0] rpage_ff, rpage_in;
   logic rdirty_ff, rdirty_in, found_ff, found_in;
   logic ov_ff, ov_in, last_ff, last_in;
   logic [1:0] kind_ff, kind_in;
   logic [2:0] st_ff, st_in;
   logic [3:0] fr_ff, fr_in;
   logic [FILE_ID_BITS-1:0] of_ff, of_in;
   logic [PAGE_BITS-1:0] op_ff, op_in;
   logic [IW-1:0] nh;
   logic [IW-1:0] match_idx;
   logic match_any;

   assign nh = (hand_ff == IW'(NUM_FRAMES - 1)) ? '0 : hand_ff + IW'(1);

   // lowest-index tag match, parallel compare with priority pick
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && file_ff[i] == rfile_ff && page_ff[i] == rpage_ff) begin
            match_any = 1'b1;
            match_idx = IW'(i);
         end
      end
   end

   always_comb begin
      stat.req_type      = type_ff;
      stat.hit           = found_ff;
      stat.hit_zero_pins = pins_ff[hit_ff] == 8'd0;
      stat.hand_free     = !valid_ff[nh];
      stat.hand_ref      = ref_ff[nh];
      stat.hand_take     = valid_ff[nh] && !ref_ff[nh] && pins_ff[nh] == 8'd0;
      stat.hand_dirty    = dirty_ff[nh];
      stat.sweep_done    = steps_ff == SW'(SWEEP_ROUNDS_N);
      stat.walk_match    = valid_ff[walk_ff] && file_ff[walk_ff] == rfile_ff;
      stat.walk_pinned   = pins_ff[walk_ff] != 8'd0;
      stat.walk_dirty    = dirty_ff[walk_ff];
      stat.walk_end      = walk_ff == IW'(NUM_FRAMES - 1);
      stat.out_busy      = ov_ff && !out_ready;
   end

   always_comb begin
      valid_in = valid_ff; dirty_in = dirty_ff; ref_in = ref_ff;
      pins_in = pins_ff; file_in = file_ff; page_in = page_ff;
      hand_in = hand_ff; walk_in = walk_ff; grant_in = grant_ff;
      steps_in = steps_ff; type_in = type_ff; rfile_in = rfile_ff; rpage_in = rpage_ff;
      rdirty_in = rdirty_ff;
      found_in = match_any;
      hit_in = match_idx;
      ov_in = ov_ff && !out_ready;
      kind_in = kind_ff; st_in = st_ff; fr_in = fr_ff; of_in = of_ff; op_in = op_ff;
      last_in = last_ff;
      case (cmd.op)
         cbpm_pkg::OP_LATCH: begin
            type_in = in_type; rfile_in = in_file; rpage_in = in_page; rdirty_in = in_dirty;
            steps_in = '0; walk_in = '0;
         end
         cbpm_pkg::OP_HIT: begin
            ref_in[hit_ff] = 1'b1;
            if (pins_ff[hit_ff] != 8'hff) pins_in[hit_ff] = pins_ff[hit_ff] + 8'd1;
            grant_in = hit_ff;
         end
         cbpm_pkg::OP_GRANT_HIT: begin
            grant_in = hit_ff;
         end
         cbpm_pkg::OP_UNPIN: begin
            pins_in[hit_ff] = pins_ff[hit_ff] - 8'd1;
            if (rdirty_ff) dirty_in[hit_ff] = 1'b1;
            grant_in = hit_ff;
         end
         cbpm_pkg::OP_WIPE_HIT: begin
            grant_in = found_ff ? hit_ff : '0;
            if (found_ff) begin
               valid_in[hit_ff] = 1'b0; dirty_in[hit_ff] = 1'b0; ref_in[hit_ff] = 1'b0;
               pins_in[hit_ff] = '0; file_in[hit_ff] = '0; page_in[hit_ff] = '0;
            end
         end
         cbpm_pkg::OP_SWEEP: begin
            hand_in = nh;
            if (valid_ff[nh] && ref_ff[nh]) ref_in[nh] = 1'b0;
            steps_in = steps_ff + SW'(1);
            grant_in = nh;
         end
         cbpm_pkg::OP_WB_TAKE: begin
            hand_in = nh;
            grant_in = nh;
         end
         cbpm_pkg::OP_INSTALL: begin
            valid_in[grant_ff] = 1'b1; dirty_in[grant_ff] = 1'b0; ref_in[grant_ff] = 1'b1;
            pins_in[grant_ff] = 8'd1; file_in[grant_ff] = rfile_ff;
            page_in[grant_ff] = rpage_ff;
         end
         cbpm_pkg::OP_FLUSH_STEP: begin
            if (valid_ff[walk_ff] && file_ff[walk_ff] == rfile_ff) begin
               valid_in[walk_ff] = 1'b0; dirty_in[walk_ff] = 1'b0; ref_in[walk_ff] = 1'b0;
               pins_in[walk_ff] = '0; file_in[walk_ff] = '0; page_in[walk_ff] = '0;
            end
            walk_in = walk_ff + IW'(1);
         end
         default: ;
      endcase
      if (cmd.emit) begin
         ov_in = 1'b1;
         kind_in = cmd.kind; st_in = cmd.status; last_in = cmd.last;
         of_in = '0; op_in = '0; fr_in = '0;
         if (cmd.use_walk) begin
            fr_in = 4'(walk_ff); of_in = file_ff[walk_ff]; op_in = page_ff[walk_ff];
         end else if (cmd.kind == cbpm_pkg::KIND_WB) begin
            fr_in = 4'(nh); of_in = file_ff[nh]; op_in = page_ff[nh];
         end else if (cmd.kind == cbpm_pkg::KIND_FETCH) begin
            fr_in = 4'(grant_ff); of_in = rfile_ff; op_in = rpage_ff;
         end else if (cmd.use_frame) begin
            fr_in = 4'(grant_in);
         end
      end
      // a take also wipes the victim
      if (cmd.op == cbpm_pkg::OP_WB_TAKE) begin
         valid_in[nh] = 1'b0; dirty_in[nh] = 1'b0; ref_in[nh] = 1'b0;
         pins_in[nh] = '0; file_in[nh] = '0; page_in[nh] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; dirty_ff <= '0; ref_ff <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            pins_ff[i] <= '0; file_ff[i] <= '0; page_ff[i] <= '0;
         end
         hand_ff <= IW'(NUM_FRAMES - 1);
         ov_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; dirty_ff <= dirty_in; ref_ff <= ref_in;
         pins_ff <= pins_in; file_ff <= file_in; page_ff <= page_in;
         hand_ff <= hand_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in; hit_ff <= hit_in; grant_ff <= grant_in; steps_ff <= steps_in;
      type_ff <= type_in; rfile_ff <= rfile_in; rpage_ff <= rpage_in; rdirty_ff <= rdirty_in;
      found_ff <= found_in;
      kind_ff <= kind_in; st_ff <= st_in; fr_ff <= fr_in; of_ff <= of_in; op_ff <= op_in;
      last_ff <= last_in;
   end

   assign out_valid = ov_ff; assign out_kind = kind_ff; assign out_status = st_ff;
   assign out_frame = fr_ff; assign out_file = of_ff; assign out_page = op_ff;
   assign out_last = last_ff;
endmodule

// ===== hdl/cbpm_control.sv =====
module cbpm_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cbpm_pkg::stat_type  stat,
   output cbpm_pkg::cmd_type   cmd
);
   typedef enum logic [7:0] {
      S_IDLE    = 8'b00000001,
      S_MATCH   = 8'b00000010,
      S_DECIDE  = 8'b00000100,
      S_SWEEP   = 8'b00001000,
      S_FETCH   = 8'b00010000,
      S_FINAL   = 8'b00100000,
      S_FLUSH   = 8'b01000000,
      S_DONE    = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.op = cbpm_pkg::OP_NONE;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op = cbpm_pkg::OP_LATCH;
               state_in = S_MATCH;
            end
         end
         // tag match settles into found and hit registers
         S_MATCH: state_in = S_DECIDE;
         S_DECIDE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.last = 1'b1; cmd.kind = cbpm_pkg::KIND_STATUS;
               state_in = S_IDLE;
               case (stat.req_type)
                  cbpm_pkg::REQ_READ: begin
                     if (stat.hit) begin
                        cmd.op = cbpm_pkg::OP_HIT; cmd.use_frame = 1'b1;
                     end else begin
                        cmd.emit = 1'b0; state_in = S_SWEEP;
                     end
                  end
                  cbpm_pkg::REQ_UNPIN: begin
                     if (!stat.hit) cmd.status = cbpm_pkg::ST_NOT_FOUND;
                     else if (stat.hit_zero_pins) begin
                        cmd.status = cbpm_pkg::ST_NOT_PIN;
                        cmd.op = cbpm_pkg::OP_GRANT_HIT; cmd.use_frame = 1'b1;
                     end else begin
                        cmd.op = cbpm_pkg::OP_UNPIN; cmd.use_frame = 1'b1;
                     end
                  end
                  cbpm_pkg::REQ_ALLOC: begin
                     cmd.emit = 1'b0; state_in = S_SWEEP;
                  end
                  cbpm_pkg::REQ_DISPOSE: begin
                     cmd.op = cbpm_pkg::OP_WIPE_HIT; cmd.use_frame = 1'b1;
                  end
                  cbpm_pkg::REQ_FLUSH: begin
                     cmd.emit = 1'b0; state_in = S_FLUSH;
                  end
                  default: cmd.status = cbpm_pkg::ST_BAD;
               endcase
            end
         end
         S_SWEEP: begin
            if (stat.sweep_done) begin
               if (!stat.out_busy) begin
                  cmd.emit = 1'b1; cmd.last = 1'b1; cmd.status = cbpm_pkg::ST_EXCEEDED;
                  state_in = S_IDLE;
               end
            end else if (stat.hand_free) begin
               cmd.op = cbpm_pkg::OP_WB_TAKE;
               state_in = (stat.req_type == cbpm_pkg::REQ_READ) ? S_FETCH : S_FINAL;
            end else if (!stat.hand_ref && stat.hand_take) begin
               if (!stat.hand_dirty) begin
                  cmd.op = cbpm_pkg::OP_WB_TAKE;
                  state_in = (stat.req_type == cbpm_pkg::REQ_READ) ? S_FETCH : S_FINAL;
               end else if (!stat.out_busy) begin
                  cmd.op = cbpm_pkg::OP_WB_TAKE; cmd.emit = 1'b1;
                  cmd.kind = cbpm_pkg::KIND_WB;
                  state_in = (stat.req_type == cbpm_pkg::REQ_READ) ? S_FETCH : S_FINAL;
               end
            end else begin
               cmd.op = cbpm_pkg::OP_SWEEP;
            end
         end
         S_FETCH: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.kind = cbpm_pkg::KIND_FETCH;
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (!stat.out_busy) begin
               cmd.op = cbpm_pkg::OP_INSTALL; cmd.emit = 1'b1; cmd.last = 1'b1;
               cmd.use_frame = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (!stat.out_busy) begin
               if (stat.walk_match && stat.walk_pinned) begin
                  cmd.emit = 1'b1; cmd.last = 1'b1; cmd.status = cbpm_pkg::ST_PINNED;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = cbpm_pkg::OP_FLUSH_STEP;
                  if (stat.walk_match && stat.walk_dirty) begin
                     cmd.emit = 1'b1; cmd.kind = cbpm_pkg::KIND_WB; cmd.use_walk = 1'b1;
                  end
                  if (stat.walk_end) state_in = S_DONE;
               end
            end
         end
         // flush end: plain ok status, frame 0
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1; cmd.last = 1'b1; cmd.kind = cbpm_pkg::KIND_STATUS;
               cmd.status = cbpm_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
